/* sv/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check on clk, switched off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/lzd_pkg.sv */
package lzd_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_DEPTH_DEF = 32768;
  localparam int DRAIN_MAX_DEF    = 64;
  localparam int LENGTH_BITS_DEF  = 24;

  // Fixed field widths.
  localparam int DIST_W    = 15;
  localparam int WRITTEN_W = 24;
  localparam int CSIZE_W   = 16;

  localparam logic [WRITTEN_W-1:0] WRITTEN_MAX = 24'hFFFFFF;
  localparam logic [CSIZE_W-1:0]   CONSUMED_MAX = 16'hFFFF;

  // Opcode boundaries and length constants.
  localparam logic [7:0] OP_FIRST   = 8'h10;
  localparam logic [7:0] OP_END     = 8'h11;
  localparam logic [7:0] OP_FAR_LO  = 8'h12;
  localparam logic [7:0] OP_FAR_HI  = 8'h1F;
  localparam logic [7:0] OP_LONG    = 8'h20;
  localparam logic [7:0] OP_SHORT   = 8'h21;
  localparam logic [7:0] OP_WIDE    = 8'h40;
  localparam logic [7:0] MATCH_BIAS = 8'h1E;
  localparam logic [7:0] NIB_MASK   = 8'h0F;
  localparam logic [7:0] EXT_STEP   = 8'hFF;
  localparam logic [7:0] LONG_ADD_A = 8'h21;
  localparam logic [7:0] LONG_ADD_B = 8'h09;
  localparam logic [DIST_W-1:0] FAR_BASE = 15'h4000;

  typedef enum logic [3:0] {
    PH_LEN, PH_LEN_EXT, PH_OPCODE, PH_OP2, PH_LONG,
    PH_LONG_EXT, PH_OFF1, PH_OFF2, PH_LIT, PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {END_RUN, END_DONE, END_FAIL} end_t;

  typedef enum logic [2:0] {
    ST_OK, ST_DONE, ST_BAD_OP, ST_FAR, ST_REFUSED, ST_OVERFLOW
  } status_t;

  typedef enum logic {FN_FEED, FN_DRAIN} func_t;

  typedef enum logic {S_IDLE, S_DRAIN} fsm_t;

endpackage

/* sv/lzd_ram.sv */
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle; rdata holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/lz77_section_decompressor.sv */
// LZ77 section decompressor for R2004-style compressed sections.
// Input items: in_tuser selects the kind (0 feeds the byte in in_tdata,
// 1 drains pending match bytes). Every feed item gives one result item in the
// cycle after it is accepted: a literal byte, or an empty item with a status.
// A drain item copies up to DRAIN_MAX bytes of the pending match out of the
// history window. The first window read is issued in the cycle after the item
// is accepted, and the copied bytes then follow one per cycle while out_tready
// allows. The window is one RAM with one write and one registered read port.
// A new item is taken only when the previous one has produced all its results.
// Results leave through one output register; while out_tready is low the
// register holds and in_tready stays low, and a drain item pauses in place.
// The compressed size is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset (rst_n low, synchronous) returns the parser to the first literal run
// and clears the counters; the window contents are left as they are, since no
// entry is read before it has been written.
module lz77_section_decompressor
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int DRAIN_MAX    = DRAIN_MAX_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: compressed size of the section.
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] func
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [10:8] status, [11] more_pending
  output logic        out_tuser,  // [0] out_valid
  output logic        out_tlast   // last
);

  `include "assert_macros.svh"

  localparam int LB = LENGTH_BITS;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int NW = $clog2(DRAIN_MAX + 1);
  localparam logic [LB:0] LEN_MAX = {1'b0, {LB{1'b1}}};

  typedef struct packed {
    phase_t            phase;
    logic [7:0]        held;
    logic [LB-1:0]     mrem;
    logic [LB-1:0]     lrem;
    logic [DIST_W-1:0] mdist;
    end_t              ended;
  } pst_t;

  // Parser helpers.
  function automatic pst_t f_start(input pst_t s, input logic [7:0] op, output status_t st);
    pst_t r;
    r = s;
    r.held = op;
    st = ST_OK;
    if (op == OP_END) begin
      r.ended = END_DONE;
      st = ST_DONE;
    end else if (op < OP_FIRST) begin
      r.ended = END_FAIL;
      st = ST_BAD_OP;
    end else if (op >= OP_WIDE) begin
      r.phase = PH_OP2;
    end else if (op >= OP_SHORT) begin
      r.mrem = LB'(op - MATCH_BIAS);
      r.phase = PH_OFF1;
    end else if (op == OP_LONG || op == OP_FIRST) begin
      r.phase = PH_LONG;
    end else begin
      r.mrem = LB'(op & NIB_MASK) + LB'(2);
      r.phase = PH_OFF1;
    end
    return r;
  endfunction

  function automatic pst_t f_boundary(input pst_t s, input logic [CSIZE_W-1:0] cons,
                                      input logic [CSIZE_W-1:0] csize, output status_t st);
    pst_t r;
    logic [7:0] op;
    r = s;
    op = s.held;
    st = ST_OK;
    if (cons >= csize) begin
      r.ended = END_DONE;
      st = ST_DONE;
    end else if (op != 8'h00) begin
      r.held = 8'h00;
      r = f_start(r, op, st);
    end else begin
      r.phase = PH_OPCODE;
    end
    return r;
  endfunction

  function automatic pst_t f_setlit(input pst_t s, input logic [LB-1:0] len,
                                    input logic [7:0] op, input logic [WRITTEN_W-1:0] wr,
                                    input logic [CSIZE_W-1:0] cons,
                                    input logic [CSIZE_W-1:0] csize, output status_t st);
    pst_t r;
    r = s;
    r.lrem = len;
    r.held = op;
    st = ST_OK;
    if (s.mrem != '0) begin
      if (WRITTEN_W'(s.mdist) > wr) begin
        r.ended = END_FAIL;
        st = ST_FAR;
      end else begin
        r.phase = PH_DRAIN;
      end
    end else if (len != '0) begin
      r.phase = PH_LIT;
    end else begin
      r = f_boundary(r, cons, csize, st);
    end
    return r;
  endfunction

  function automatic pst_t f_after(input pst_t s, input logic [1:0] lit2,
                                   input logic [WRITTEN_W-1:0] wr,
                                   input logic [CSIZE_W-1:0] cons,
                                   input logic [CSIZE_W-1:0] csize, output status_t st);
    pst_t r;
    r = s;
    st = ST_OK;
    if (lit2 != 2'd0) begin
      r = f_setlit(s, LB'(lit2), 8'h00, wr, cons, csize, st);
    end else begin
      r.phase = PH_LEN;
    end
    return r;
  endfunction

  function automatic pst_t f_finlong(input pst_t s, input logic [LB:0] total,
                                     output status_t st);
    pst_t r;
    logic [LB:0] sum;
    r = s;
    st = ST_OK;
    sum = total + (LB+1)'((s.held == OP_LONG) ? LONG_ADD_A : LONG_ADD_B);
    if (sum > LEN_MAX) begin
      r.ended = END_FAIL;
      st = ST_OVERFLOW;
    end else begin
      r.mrem = sum[LB-1:0];
      r.phase = PH_OFF1;
    end
    return r;
  endfunction

  // Registers.
  fsm_t                 state_r, state_nxt;
  pst_t                 ps_r, ps_nxt;
  logic [LB-1:0]        acc_r, acc_nxt;
  logic [7:0]           first_r, first_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [WRITTEN_W-1:0] written_r, written_nxt;
  logic [CSIZE_W-1:0]   consumed_r, consumed_nxt;
  logic [CSIZE_W-1:0]   comp_size_r;
  logic [LB-1:0]        iss_rem_r, iss_rem_nxt;
  logic [NW-1:0]        iss_n_r, iss_n_nxt;
  logic [NW-1:0]        cons_n_r, cons_n_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [7:0]           fwd_byte_r, fwd_byte_nxt;
  logic                 ob_valid_r, ob_valid_nxt;
  logic [7:0]           ob_byte_r, ob_byte_nxt;
  logic                 ob_v_r, ob_v_nxt;
  status_t              ob_st_r, ob_st_nxt;
  logic                 ob_pend_r, ob_pend_nxt;
  logic                 ob_last_r, ob_last_nxt;

  // Window port signals.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_q;

  // Feed results.
  pst_t               fd_ps;
  status_t            fd_st;
  logic               fd_ov;
  logic [LB-1:0]      fd_acc;
  logic [7:0]         fd_first;
  logic [CSIZE_W-1:0] fd_consumed;

  logic       out_free, consume, issue;
  logic [7:0] drain_data;

  assign out_free   = !ob_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign drain_data = fwd_r ? fwd_byte_r : ram_q;

  lzd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Parse one compressed byte.
  always_comb begin
    pst_t        s;
    status_t     st;
    logic [LB:0] sum;
    logic [13:0] off;
    logic        far;
    s = ps_r;
    st = ST_OK;
    sum = '0;
    off = '0;
    far = 1'b0;
    fd_acc = acc_r;
    fd_first = first_r;
    fd_ov = 1'b0;
    fd_consumed = (consumed_r == CONSUMED_MAX) ? consumed_r : consumed_r + 1'b1;
    case (ps_r.phase)
      PH_LEN: begin
        if (in_tdata >= 8'h01 && in_tdata <= NIB_MASK) begin
          s = f_setlit(s, LB'(in_tdata) + LB'(3), 8'h00, written_r, fd_consumed,
                       comp_size_r, st);
        end else if (in_tdata == 8'h00) begin
          fd_acc = LB'(NIB_MASK);
          s.phase = PH_LEN_EXT;
        end else begin
          s = f_setlit(s, '0, (ps_r.mrem != '0) ? in_tdata : 8'h00, written_r,
                       fd_consumed, comp_size_r, st);
        end
      end
      PH_LEN_EXT, PH_LONG_EXT: begin
        if (in_tdata == 8'h00) begin
          sum = {1'b0, acc_r} + (LB+1)'(EXT_STEP);
          fd_acc = sum[LB-1:0];
          if (sum > LEN_MAX) begin
            s.ended = END_FAIL;
            st = ST_OVERFLOW;
          end
        end else if (ps_r.phase == PH_LONG_EXT) begin
          s = f_finlong(s, {1'b0, acc_r} + (LB+1)'(in_tdata), st);
        end else begin
          sum = {1'b0, acc_r} + (LB+1)'(in_tdata) + (LB+1)'(3);
          if (sum > LEN_MAX) begin
            s.ended = END_FAIL;
            st = ST_OVERFLOW;
          end else begin
            s = f_setlit(s, sum[LB-1:0], 8'h00, written_r, fd_consumed, comp_size_r, st);
          end
        end
      end
      PH_OPCODE: begin
        s = f_start(s, in_tdata, st);
      end
      PH_OP2: begin
        s.mrem = LB'(ps_r.held[7:4]) - LB'(1);
        s.mdist = DIST_W'({in_tdata, ps_r.held[3:2]}) + DIST_W'(1);
        s = f_after(s, ps_r.held[1:0], written_r, fd_consumed, comp_size_r, st);
      end
      PH_LONG: begin
        if (in_tdata == 8'h00) begin
          fd_acc = LB'(EXT_STEP);
          s.phase = PH_LONG_EXT;
        end else begin
          s = f_finlong(s, (LB+1)'(in_tdata), st);
        end
      end
      PH_OFF1: begin
        fd_first = in_tdata;
        s.phase = PH_OFF2;
      end
      PH_OFF2: begin
        off = {in_tdata, first_r[7:2]};
        far = (ps_r.held == OP_FIRST) ||
              (ps_r.held >= OP_FAR_LO && ps_r.held <= OP_FAR_HI);
        s.mdist = far ? DIST_W'(off) + FAR_BASE : DIST_W'(off) + DIST_W'(1);
        s = f_after(s, first_r[1:0], written_r, fd_consumed, comp_size_r, st);
      end
      default: begin
        // Literal byte: passes out and into the window.
        fd_ov = 1'b1;
        if (s.lrem != '0) begin
          s.lrem = s.lrem - 1'b1;
        end
        if (s.lrem == '0) begin
          s = f_boundary(s, fd_consumed, comp_size_r, st);
        end
      end
    endcase
    fd_ps = s;
    fd_st = st;
  end

  // Sequencer: item handling, window writes and match copy reads.
  always_comb begin
    pst_t          s;
    status_t       st;
    logic [LB-1:0] mrem_new;
    logic [AW-1:0] wp_after;
    logic          lastf;
    s = ps_r;
    st = ST_OK;
    mrem_new = ps_r.mrem;
    wp_after = wp_r;
    lastf = 1'b0;
    state_nxt = state_r;
    ps_nxt = ps_r;
    acc_nxt = acc_r;
    first_nxt = first_r;
    wp_nxt = wp_r;
    written_nxt = written_r;
    consumed_nxt = consumed_r;
    iss_rem_nxt = iss_rem_r;
    iss_n_nxt = iss_n_r;
    cons_n_nxt = cons_n_r;
    rd_pend_nxt = rd_pend_r;
    fwd_nxt = fwd_r;
    fwd_byte_nxt = fwd_byte_r;
    ob_valid_nxt = ob_valid_r && !out_tready;
    ob_byte_nxt = ob_byte_r;
    ob_v_nxt = ob_v_r;
    ob_st_nxt = ob_st_r;
    ob_pend_nxt = ob_pend_r;
    ob_last_nxt = ob_last_r;
    ram_we = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = in_tdata;
    ram_re = 1'b0;
    ram_raddr = wp_r;
    consume = 1'b0;
    issue = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          ob_valid_nxt = 1'b1;
          ob_byte_nxt = 8'h00;
          ob_v_nxt = 1'b0;
          ob_st_nxt = ST_OK;
          ob_pend_nxt = 1'b0;
          ob_last_nxt = 1'b1;
          if (ps_r.ended != END_RUN) begin
            ob_st_nxt = (ps_r.ended == END_DONE) ? ST_DONE : ST_REFUSED;
          end else if (in_tuser == FN_FEED) begin
            if (ps_r.phase == PH_DRAIN) begin
              ob_st_nxt = ST_REFUSED;
              ob_pend_nxt = 1'b1;
            end else begin
              consumed_nxt = fd_consumed;
              ps_nxt = fd_ps;
              acc_nxt = fd_acc;
              first_nxt = fd_first;
              ob_byte_nxt = fd_ov ? in_tdata : 8'h00;
              ob_v_nxt = fd_ov;
              ob_st_nxt = fd_st;
              ob_pend_nxt = (fd_ps.phase == PH_DRAIN) && (fd_ps.ended == END_RUN);
              if (fd_ov) begin
                ram_we = 1'b1;
                wp_nxt = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
                written_nxt = (written_r == WRITTEN_MAX) ? written_r : written_r + 1'b1;
              end
            end
          end else if (ps_r.phase == PH_DRAIN) begin
            // Start a copy run: no result until the first window read returns.
            ob_valid_nxt = 1'b0;
            state_nxt = S_DRAIN;
            iss_rem_nxt = ps_r.mrem;
            iss_n_nxt = '0;
            cons_n_nxt = '0;
            rd_pend_nxt = 1'b0;
            fwd_nxt = 1'b0;
          end
        end
      end
      S_DRAIN: begin
        // Retire the pending byte read: emit it and append it to the window.
        consume = rd_pend_r && out_free;
        if (consume) begin
          mrem_new = ps_r.mrem - 1'b1;
          s.mrem = mrem_new;
          wp_after = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
          ram_we = 1'b1;
          ram_wdata = drain_data;
          wp_nxt = wp_after;
          written_nxt = (written_r == WRITTEN_MAX) ? written_r : written_r + 1'b1;
          cons_n_nxt = cons_n_r + 1'b1;
          lastf = (mrem_new == '0) || (cons_n_r + 1'b1 == NW'(DRAIN_MAX));
          if (mrem_new == '0) begin
            if (s.lrem != '0) begin
              s.phase = PH_LIT;
            end else begin
              s = f_boundary(s, consumed_r, comp_size_r, st);
            end
          end
          ps_nxt = s;
          ob_valid_nxt = 1'b1;
          ob_byte_nxt = drain_data;
          ob_v_nxt = 1'b1;
          ob_st_nxt = lastf ? st : ST_OK;
          ob_pend_nxt = (mrem_new != '0);
          ob_last_nxt = lastf;
          if (lastf) begin
            state_nxt = S_IDLE;
          end
        end
        // Read the next match byte; distance one reads the byte written now.
        issue = (iss_rem_r != '0) && (iss_n_r != NW'(DRAIN_MAX)) && (!rd_pend_r || consume);
        if (issue) begin
          ram_re = 1'b1;
          if ({1'b0, wp_after} >= (AW+1)'(ps_r.mdist)) begin
            ram_raddr = wp_after - AW'(ps_r.mdist);
          end else begin
            ram_raddr = AW'({1'b0, wp_after} + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(ps_r.mdist));
          end
          iss_rem_nxt = iss_rem_r - 1'b1;
          iss_n_nxt = iss_n_r + 1'b1;
          fwd_nxt = consume && (ps_r.mdist == DIST_W'(1));
          fwd_byte_nxt = drain_data;
          rd_pend_nxt = 1'b1;
        end else if (consume) begin
          rd_pend_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ps_r <= '{phase: PH_LEN, held: '0, mrem: '0, lrem: '0, mdist: '0, ended: END_RUN};
      acc_r <= '0;
      first_r <= '0;
      wp_r <= '0;
      written_r <= '0;
      consumed_r <= '0;
      comp_size_r <= '0;
      iss_rem_r <= '0;
      iss_n_r <= '0;
      cons_n_r <= '0;
      rd_pend_r <= 1'b0;
      fwd_r <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ps_r <= ps_nxt;
      acc_r <= acc_nxt;
      first_r <= first_nxt;
      wp_r <= wp_nxt;
      written_r <= written_nxt;
      consumed_r <= consumed_nxt;
      if (cfg_we) begin
        comp_size_r <= cfg_wdata;
      end
      iss_rem_r <= iss_rem_nxt;
      iss_n_r <= iss_n_nxt;
      cons_n_r <= cons_n_nxt;
      rd_pend_r <= rd_pend_nxt;
      fwd_r <= fwd_nxt;
      ob_valid_r <= ob_valid_nxt;
    end
  end

  // Result payload and forwarded byte need no reset.
  always_ff @(posedge clk) begin
    fwd_byte_r <= fwd_byte_nxt;
    ob_byte_r <= ob_byte_nxt;
    ob_v_r <= ob_v_nxt;
    ob_st_r <= ob_st_nxt;
    ob_pend_r <= ob_pend_nxt;
    ob_last_r <= ob_last_nxt;
  end

  assign out_tvalid = ob_valid_r;
  assign out_tdata  = {4'b0000, ob_pend_r, ob_st_r, ob_byte_r};
  assign out_tuser  = ob_v_r;
  assign out_tlast  = ob_last_r;

  // A window read is only outstanding inside a copy run.
  `ASSERT_CLK(a_pend_in_drain, rd_pend_r |-> (state_r == S_DRAIN), "read pending outside drain")
  // Forwarding is only used for a copy at distance one.
  `ASSERT_CLK(a_fwd_dist, (rd_pend_r && fwd_r) |-> (ps_r.mdist == DIST_W'(1)), "bad forward")
  // A stalled result is never overwritten by a retiring copy byte.
  `ASSERT_CLK(a_no_overrun, (ob_valid_r && !out_tready) |=> $stable(ob_byte_r), "result lost")
  // An ended section never starts a copy run.
  `ASSERT_CLK(a_end_idle, (ps_r.ended != END_RUN) |-> !rd_pend_r, "copy after end")

endmodule
